[rtl/cfs_pkg.sv]
// cfs_pkg: shared constants and types of the command frame segmenter.
// Used by cfs_front, cfs_back and command_frame_segmenter; no dependencies.
`default_nettype none
package cfs_pkg;
	localparam int FRAME_BYTES_DEF = 8;
	localparam int MAX_FRAME       = 8;
	localparam int LEN_W           = 4;
	localparam int QUEUE_DEPTH     = 4;
	localparam int PTR_W           = $clog2(QUEUE_DEPTH);
	localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
	localparam logic [7:0] TRAILER_BYTE = 8'h6B;

	// one classified item on its way from front to back
	typedef struct packed {
		logic [7:0] payload;
		logic [7:0] address;
		logic       first;
		logic       last;
	} cfs_item_t;

	typedef logic [MAX_FRAME-1:0][7:0] cfs_data_t;
endpackage
`default_nettype wire

[rtl/cfs_front.sv]
// cfs_front: accepts payload items, marks the first byte of each command and
// queues them for the frame builder. Depends on cfs_pkg.
`default_nettype none
module cfs_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire logic [7:0]       payload_byte,
	input  wire logic [7:0]       motor_address,
	input  wire logic             last_byte,
	output logic                  q_valid,
	output cfs_pkg::cfs_item_t    q_item,
	input  wire logic             q_pop
);
	import cfs_pkg::*;

	cfs_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             in_cmd_q;
	logic             push;

	assign item_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != '0);
	assign q_item     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
			in_cmd_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q     <= wr_q + 1'b1;
				in_cmd_q <= !last_byte;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{payload: payload_byte, address: motor_address,
				first: !in_cmd_q, last: last_byte};
		end
	end
endmodule
`default_nettype wire

[rtl/cfs_back.sv]
// cfs_back: builds bus frames from queued items and holds them in the output
// register; emits a second trailer frame when the last byte fills a frame. Depends on cfs_pkg.
`default_nettype none
module cfs_back #(
	parameter int FRAME_BYTES = cfs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_valid,
	input  wire cfs_pkg::cfs_item_t      q_item,
	output logic                         q_pop,
	output logic                         frame_valid,
	input  wire logic                    frame_ready,
	output logic [15:0]                  frame_id,
	output logic [cfs_pkg::LEN_W-1:0]    frame_len,
	output cfs_pkg::cfs_data_t           frame_data,
	output logic                         final_frame
);
	import cfs_pkg::*;

	logic [7:0]       store_q [FRAME_BYTES];
	logic [LEN_W-1:0] fill_q;
	logic [7:0]       pkt_q;
	logic [7:0]       code_q;
	logic [7:0]       addr_q;
	logic             pend_q;
	logic             frame_valid_q;
	logic [15:0]      frame_id_q;
	logic [LEN_W-1:0] frame_len_q;
	cfs_data_t        frame_data_q;
	logic             final_frame_q;

	logic [LEN_W-1:0] fill_eff;
	logic [LEN_W-1:0] fill_n;
	logic [7:0]       pkt_eff;
	logic [7:0]       code_eff;
	logic [7:0]       addr_eff;
	logic             full;
	logic             emits;
	logic             slot_free;
	logic             load_pend;
	logic             with_trailer;
	cfs_data_t        build_data;
	cfs_data_t        tail_data;
	logic [LEN_W-1:0] build_len;

	always_comb begin
		fill_eff     = q_item.first ? '0 : fill_q;
		pkt_eff      = q_item.first ? '0 : pkt_q;
		code_eff     = q_item.first ? q_item.payload : code_q;
		addr_eff     = q_item.first ? q_item.address : addr_q;
		fill_n       = fill_eff + 1'b1;
		full         = (fill_n == LEN_W'(FRAME_BYTES));
		emits        = q_item.last || full;
		with_trailer = q_item.last && !full;
		slot_free    = !frame_valid_q || frame_ready;
		load_pend    = pend_q && slot_free;
		// hold the queue while a trailer frame waits its turn
		q_pop        = q_valid && !pend_q && (slot_free || !emits);
		build_len    = with_trailer ? fill_n + 1'b1 : fill_n;
		build_data   = '0;
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (LEN_W'(i) < fill_eff) begin
				build_data[i] = store_q[i];
			end else if (LEN_W'(i) == fill_eff) begin
				build_data[i] = q_item.payload;
			end else if (LEN_W'(i) == fill_n && with_trailer) begin
				build_data[i] = TRAILER_BYTE;
			end
		end
		tail_data    = '0;
		tail_data[0] = code_q;
		tail_data[1] = TRAILER_BYTE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			pkt_q         <= '0;
			code_q        <= '0;
			addr_q        <= '0;
			pend_q        <= 1'b0;
			frame_valid_q <= 1'b0;
		end else begin
			if (load_pend || (q_pop && emits)) begin
				frame_valid_q <= 1'b1;
			end else if (frame_ready) begin
				frame_valid_q <= 1'b0;
			end
			if (load_pend) begin
				pend_q        <= 1'b0;
				pkt_q         <= '0;
			end else if (q_pop) begin
				code_q <= code_eff;
				addr_q <= addr_eff;
				if (!full) begin
					fill_q <= q_item.last ? '0 : fill_n;
					pkt_q  <= pkt_eff;
				end else begin
					// next frame opens with the function code
					fill_q <= q_item.last ? '0 : LEN_W'(1);
					pkt_q  <= pkt_eff + 1'b1;
					pend_q <= q_item.last;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_pend) begin
			frame_id_q    <= {addr_q, pkt_q};
			frame_len_q   <= LEN_W'(2);
			frame_data_q  <= tail_data;
			final_frame_q <= 1'b1;
		end else if (q_pop && emits) begin
			frame_id_q    <= {addr_eff, pkt_eff};
			frame_len_q   <= build_len;
			frame_data_q  <= build_data;
			final_frame_q <= with_trailer;
		end
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (q_pop && !load_pend && !q_item.last) begin
				if (!full && LEN_W'(i) == fill_eff) begin
					store_q[i] <= q_item.payload;
				end else if (full && i == 0) begin
					store_q[i] <= code_eff;
				end
			end
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_id    = frame_id_q;
	assign frame_len   = frame_len_q;
	assign frame_data  = frame_data_q;
	assign final_frame = final_frame_q;
endmodule
`default_nettype wire

[rtl/command_frame_segmenter.sv]
// command_frame_segmenter: top level; cuts byte-serial commands into bus frames.
// Instantiates cfs_front and cfs_back; depends on cfs_pkg.
//
// Input channel (item_valid/item_ready): one payload byte per item with the
// motor address (sampled on the first byte of a command) and a last-byte mark.
// Output channel (frame_valid/frame_ready): bus frames, each with
// identifier {address, packet number}, length, eight data bytes (unused ones
// zero) and a final-frame mark. The trailer byte 0x6B follows the last byte.
// Throughput: one input item per cycle while the input queue has room. A command
// whose last byte fills a frame yields two frames.
// A byte that completes a frame is first written into the four-entry input
// queue; the frame builder then takes it and, once the output register is free,
// registers the frame there.
// The queue decouples the two sides: while the receiver stalls, input items
// keep arriving until the queue is full; bytes that do not finish a frame are
// absorbed by the builder even with a frame waiting, unless a trailer frame is pending.
// Reset clears the queue, the frame builder and the output valid flag; no
// command is in progress afterwards.
`default_nettype none
module command_frame_segmenter #(
	parameter int FRAME_BYTES = cfs_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire logic [7:0]            payload_byte,
	input  wire logic [7:0]            motor_address,
	input  wire logic                  last_byte,
	output logic                       frame_valid,
	input  wire logic                  frame_ready,
	output logic [15:0]                frame_id,
	output logic [cfs_pkg::LEN_W-1:0]  frame_len,
	output logic [7:0]                 data_0,
	output logic [7:0]                 data_1,
	output logic [7:0]                 data_2,
	output logic [7:0]                 data_3,
	output logic [7:0]                 data_4,
	output logic [7:0]                 data_5,
	output logic [7:0]                 data_6,
	output logic [7:0]                 data_7,
	output logic                       final_frame
);
	import cfs_pkg::*;

	logic      q_valid;
	logic      q_pop;
	cfs_item_t q_item;
	cfs_data_t frame_data;

	cfs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.payload_byte  (payload_byte),
		.motor_address (motor_address),
		.last_byte     (last_byte),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	cfs_back #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_id    (frame_id),
		.frame_len   (frame_len),
		.frame_data  (frame_data),
		.final_frame (final_frame)
	);

	assign data_0 = frame_data[0];
	assign data_1 = frame_data[1];
	assign data_2 = frame_data[2];
	assign data_3 = frame_data[3];
	assign data_4 = frame_data[4];
	assign data_5 = frame_data[5];
	assign data_6 = frame_data[6];
	assign data_7 = frame_data[7];

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("builder took an item from an empty queue");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid |-> (frame_len != '0 && frame_len <= LEN_W'(FRAME_BYTES)))
		else $error("frame length out of range");

	a_mid_frame_full: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && !final_frame) |-> (frame_len == LEN_W'(FRAME_BYTES)))
		else $error("non-final frame is not full");

	a_final_has_trailer: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_valid && final_frame) |-> (frame_len >= LEN_W'(2)))
		else $error("final frame too short to carry the trailer");
endmodule
`default_nettype wire

[dv/tb.sv]
// tb: self-checking testbench for command_frame_segmenter.
// Predicts the frames of each command and checks them against the output channel.
// Depends on cfs_pkg and the command_frame_segmenter RTL.
`timescale 1ns / 100ps
module tb;
	import cfs_pkg::*;

	localparam int FRAME_BYTES = FRAME_BYTES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 16;

	typedef struct packed {
		logic [7:0] payload;
		logic [7:0] address;
		logic       last;
	} byte_item_t;

	typedef struct packed {
		logic [15:0]      id;
		logic [LEN_W-1:0] len;
		cfs_data_t        data;
		logic             fin;
	} frame_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	logic [7:0]       payload_byte = 8'h00;
	logic [7:0]       motor_address = 8'h00;
	logic             last_byte = 1'b0;
	logic             frame_valid;
	logic             frame_ready = 1'b0;
	logic [15:0]      frame_id;
	logic [LEN_W-1:0] frame_len;
	logic [7:0]       data_0, data_1, data_2, data_3, data_4, data_5, data_6, data_7;
	logic             final_frame;

	byte_item_t bytes_to_send[$];
	frame_t     frames_due[$];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         mismatches = 0;
	int         frames_seen = 0;
	int         quiet_cycles = 0;

	// predictor state
	cfs_data_t        frame_bytes = '0;
	logic [LEN_W-1:0] fill = '0;
	logic [7:0]       packet_no = '0;
	logic [7:0]       func_code = '0;
	logic [7:0]       cmd_address = '0;
	logic             in_cmd = 1'b0;

	command_frame_segmenter #(.FRAME_BYTES(FRAME_BYTES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.payload_byte(payload_byte),
		.motor_address(motor_address),
		.last_byte(last_byte),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_id(frame_id),
		.frame_len(frame_len),
		.data_0(data_0),
		.data_1(data_1),
		.data_2(data_2),
		.data_3(data_3),
		.data_4(data_4),
		.data_5(data_5),
		.data_6(data_6),
		.data_7(data_7),
		.final_frame(final_frame)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task report_mismatch(input string msg);
		$display("[%0t] frame %0d: %s", $realtime, frames_seen, msg);
		mismatches++;
	endtask

	function void store_byte(input logic [7:0] b);
		if (fill < MAX_FRAME) begin
			frame_bytes[fill[2:0]] = b;
			fill++;
		end
	endfunction

	function void emit_frame(input logic fin);
		frame_t f;
		f.id = {cmd_address, packet_no};
		f.len = fill;
		f.data = '0;
		for (int i = 0; i < MAX_FRAME; i++)
			if (i < fill)
				f.data[i] = frame_bytes[i];
		f.fin = fin;
		frames_due.push_back(f);
	endfunction

	// close the current frame and open the next one with the function code
	function void roll_frame();
		emit_frame(1'b0);
		packet_no++;
		fill = '0;
		store_byte(func_code);
	endfunction

	function void segment_byte(input logic [7:0] b, input logic [7:0] a, input logic last);
		if (!in_cmd) begin
			func_code = b;
			cmd_address = a;
			packet_no = '0;
			fill = '0;
			in_cmd = 1'b1;
		end
		store_byte(b);
		if (fill >= FRAME_BYTES)
			roll_frame();
		if (last) begin
			store_byte(TRAILER_BYTE);
			emit_frame(1'b1);
			fill = '0;
			packet_no = '0;
			in_cmd = 1'b0;
		end
	endfunction

	task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h expected %h", name, got, want));
	endtask

	// driver: present the next pending item once the current one is taken
	always @(posedge clk or negedge arst_n) begin : drive
		byte_item_t it;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				segment_byte(payload_byte, motor_address, last_byte);
			if (!item_valid || item_ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = bytes_to_send.pop_front();
					item_valid <= 1'b1;
					payload_byte <= it.payload;
					motor_address <= it.address;
					last_byte <= it.last;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted frame with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		frame_t    want;
		cfs_data_t got_data;
		if (!arst_n) begin
			frame_ready <= 1'b0;
		end else begin
			if (frame_valid && frame_ready) begin
				if (frames_due.size() == 0) begin
					report_mismatch($sformatf("unexpected frame id %h", frame_id));
				end else begin
					want = frames_due.pop_front();
					got_data = {data_7, data_6, data_5, data_4, data_3, data_2, data_1, data_0};
					check_field("frame_id", frame_id, want.id);
					check_field("frame_len", 16'(frame_len), 16'(want.len));
					for (int i = 0; i < MAX_FRAME; i++)
						check_field($sformatf("data_%0d", i), 16'(got_data[i]), 16'(want.data[i]));
					check_field("final_frame", 16'(final_frame), 16'(want.fin));
				end
				frames_seen++;
			end
			frame_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (frame_valid && frame_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task queue_byte(input logic [7:0] b, input logic [7:0] a, input logic last);
		byte_item_t it;
		it.payload = b;
		it.address = a;
		it.last = last;
		bytes_to_send.push_back(it);
	endtask

	// one command of len bytes; the address varies per byte but only the first counts
	task queue_command(input int len);
		for (int i = 0; i < len; i++)
			queue_byte(8'($urandom_range(255)), 8'($urandom_range(255)), i == len - 1);
	endtask

	task queue_random(input int n_bytes);
		int len;
		while (n_bytes > 0) begin
			// favor lengths that land on frame boundaries
			if ($urandom_range(1))
				len = 7 * $urandom_range(2) + $urandom_range(6, 8);
			else
				len = $urandom_range(1, 24);
			queue_command(len);
			n_bytes -= len;
		end
	endtask

	task drain();
		while (bytes_to_send.size() != 0 || item_valid || frames_due.size() != 0)
			@(posedge clk);
	endtask

	task run_phase(input int send_pct, input int stall_pct, input int n_bytes);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		queue_random(n_bytes);
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// single-byte commands at the field extremes
		queue_byte(8'h00, 8'hFF, 1'b1);
		queue_byte(8'hFF, 8'h00, 1'b1);
		// seven bytes: trailer fills the frame exactly; address changes are ignored
		for (int i = 0; i < 7; i++)
			queue_byte(8'hF0 + 8'(i), 8'h12 + 8'(i), i == 6);
		// eight bytes: frame full on the last byte, trailer spills into a second frame
		for (int i = 0; i < 8; i++)
			queue_byte(8'hA5 ^ 8'(i * 17), 8'h5A, i == 7);
		// nine bytes: frame full on a middle byte
		for (int i = 0; i < 9; i++)
			queue_byte(8'(i * 29), 8'hC3 ^ 8'(i), i == 8);
		drain();

		run_phase(0, 0, 200);
		run_phase(63, 0, 200);
		run_phase(0, 63, 200);
		run_phase(13, 13, 250);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (frames_due.size() != 0)
			report_mismatch($sformatf("%0d frames never arrived", frames_due.size()));
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
